// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of the 3x3 matrix inverse.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define MI3_ASSERT_HOLD(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("mi3 check failed: hold");

// Check that a consequent follows an antecedent.
`define MI3_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mi3 check failed: implication");

`endif

// ===== hdl/mi3_pkg.sv =====
// Types and constants shared by the 3x3 matrix inverse modules.
`default_nettype none

package mi3_pkg;

  localparam int MI3_LANES   = 9;   // one divider lane per cofactor
  localparam int MI3_QW      = 33;  // quotient bits kept before clipping
  localparam int MI3_RW      = 96;  // width of scaled cofactor and divisor
  localparam int MI3_CW      = 64;  // cofactor magnitude width
  localparam int MI3_NSTEP   = 33;  // one divider step per quotient bit
  localparam int MI3_FRONT   = 7;   // front stages
  localparam int MI3_LATENCY = MI3_FRONT + MI3_NSTEP + 2;

  // one input word: a 3x3 matrix in signed Q16.16
  typedef struct packed {
    logic signed [31:0] a_00;
    logic signed [31:0] a_01;
    logic signed [31:0] a_02;
    logic signed [31:0] a_10;
    logic signed [31:0] a_11;
    logic signed [31:0] a_12;
    logic signed [31:0] a_20;
    logic signed [31:0] a_21;
    logic signed [31:0] a_22;
  } mi3_in_t;

  // one result word
  typedef struct packed {
    logic signed [31:0] inv_00;
    logic signed [31:0] inv_01;
    logic signed [31:0] inv_02;
    logic signed [31:0] inv_10;
    logic signed [31:0] inv_11;
    logic signed [31:0] inv_12;
    logic signed [31:0] inv_20;
    logic signed [31:0] inv_21;
    logic signed [31:0] inv_22;
    logic signed [31:0] det_value;
    logic               singular;
    logic               saturated;
  } mi3_out_t;

  // front end to divider bank
  typedef struct packed {
    logic [MI3_RW-1:0]                  dmag;
    logic                               dneg;
    logic                               dzero;
    logic [MI3_LANES-1:0]               cneg;
    logic [MI3_LANES-1:0][MI3_CW-1:0]   cmag;
  } mi3_front_t;

  // sideband travelling down the divider bank
  typedef struct packed {
    logic [MI3_RW-1:0]    dmag;
    logic                 dneg;
    logic                 dzero;
    logic [MI3_LANES-1:0] cneg;
    logic [MI3_LANES-1:0] ovf;
  } mi3_side_t;

endpackage

`default_nettype wire

// ===== hdl/mi3_front.sv =====
// Front end: products, exact determinant and cofactor magnitudes.
`default_nettype none

module mi3_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  mi3_pkg::mi3_in_t   matrix_i,
  output logic               valid_o,
  output mi3_pkg::mi3_front_t side_o
);
  import mi3_pkg::*;

  logic [MI3_FRONT-1:0] vld_q;

  mi3_in_t            mat_q;
  logic signed [31:0] f_a02_q, f_a12_q, f_a22_q;
  logic signed [63:0] prod_q [18];
  logic signed [31:0] fac [6];
  logic signed [63:0] hi_q [6];
  logic signed [64:0] lo_q [6];
  logic signed [64:0] cof_q [MI3_LANES];
  logic signed [96:0] term_q [6];
  logic signed [98:0] s0_q, s1_q;
  logic signed [99:0] det_q;
  logic [MI3_LANES-1:0]             cneg4_q, cneg5_q, cneg6_q;
  logic [MI3_LANES-1:0][MI3_CW-1:0] cmag4_q, cmag5_q, cmag6_q;
  mi3_front_t side_q;

  // advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[MI3_FRONT-2:0], valid_i};
    end
  end

  // stage 1: capture the word
  always_ff @(posedge clk_i) begin
    mat_q <= matrix_i;
  end

  // stage 2: all pair products
  always_ff @(posedge clk_i) begin
    prod_q[0]  <= $signed(mat_q.a_00) * $signed(mat_q.a_11);
    prod_q[1]  <= $signed(mat_q.a_10) * $signed(mat_q.a_21);
    prod_q[2]  <= $signed(mat_q.a_20) * $signed(mat_q.a_01);
    prod_q[3]  <= $signed(mat_q.a_20) * $signed(mat_q.a_11);
    prod_q[4]  <= $signed(mat_q.a_10) * $signed(mat_q.a_01);
    prod_q[5]  <= $signed(mat_q.a_00) * $signed(mat_q.a_21);
    prod_q[6]  <= $signed(mat_q.a_11) * $signed(mat_q.a_22);
    prod_q[7]  <= $signed(mat_q.a_21) * $signed(mat_q.a_12);
    prod_q[8]  <= $signed(mat_q.a_21) * $signed(mat_q.a_02);
    prod_q[9]  <= $signed(mat_q.a_01) * $signed(mat_q.a_22);
    prod_q[10] <= $signed(mat_q.a_01) * $signed(mat_q.a_12);
    prod_q[11] <= $signed(mat_q.a_11) * $signed(mat_q.a_02);
    prod_q[12] <= $signed(mat_q.a_20) * $signed(mat_q.a_12);
    prod_q[13] <= $signed(mat_q.a_10) * $signed(mat_q.a_22);
    prod_q[14] <= $signed(mat_q.a_00) * $signed(mat_q.a_22);
    prod_q[15] <= $signed(mat_q.a_20) * $signed(mat_q.a_02);
    prod_q[16] <= $signed(mat_q.a_10) * $signed(mat_q.a_02);
    prod_q[17] <= $signed(mat_q.a_00) * $signed(mat_q.a_12);
    f_a02_q    <= $signed(mat_q.a_02);
    f_a12_q    <= $signed(mat_q.a_12);
    f_a22_q    <= $signed(mat_q.a_22);
  end

  // third factor of each Sarrus term
  assign fac[0] = f_a22_q;
  assign fac[1] = f_a02_q;
  assign fac[2] = f_a12_q;
  assign fac[3] = f_a02_q;
  assign fac[4] = f_a22_q;
  assign fac[5] = f_a12_q;

  // stage 3: split triple products into two halves, form cofactors
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      hi_q[k] <= $signed(prod_q[k][63:32]) * fac[k];
      lo_q[k] <= $signed({1'b0, prod_q[k][31:0]}) * fac[k];
    end
    cof_q[0] <= prod_q[6]  - prod_q[7];
    cof_q[1] <= prod_q[8]  - prod_q[9];
    cof_q[2] <= prod_q[10] - prod_q[11];
    cof_q[3] <= prod_q[12] - prod_q[13];
    cof_q[4] <= prod_q[14] - prod_q[15];
    cof_q[5] <= prod_q[16] - prod_q[17];
    cof_q[6] <= prod_q[1]  - prod_q[3];
    cof_q[7] <= prod_q[2]  - prod_q[5];
    cof_q[8] <= prod_q[0]  - prod_q[4];
  end

  // stage 4: join halves, take cofactor magnitudes
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      term_q[k] <= $signed({hi_q[k][63], hi_q[k], 32'b0}) + lo_q[k];
    end
    for (int j = 0; j < MI3_LANES; j++) begin
      cneg4_q[j] <= cof_q[j][64];
      cmag4_q[j] <= cof_q[j][64] ? 64'(-cof_q[j]) : cof_q[j][63:0];
    end
  end

  // stage 5: sum positive and negative terms
  always_ff @(posedge clk_i) begin
    s0_q    <= term_q[0] + term_q[1] + term_q[2];
    s1_q    <= term_q[3] + term_q[4] + term_q[5];
    cneg5_q <= cneg4_q;
    cmag5_q <= cmag4_q;
  end

  // stage 6: exact determinant
  always_ff @(posedge clk_i) begin
    det_q   <= s0_q - s1_q;
    cneg6_q <= cneg5_q;
    cmag6_q <= cmag5_q;
  end

  // stage 7: determinant sign and magnitude
  always_ff @(posedge clk_i) begin
    side_q.dneg  <= det_q[99];
    side_q.dzero <= (det_q == '0);
    side_q.dmag  <= det_q[99] ? 96'(-det_q) : det_q[95:0];
    side_q.cneg  <= cneg6_q;
    side_q.cmag  <= cmag6_q;
  end

  assign valid_o = vld_q[MI3_FRONT-1];
  assign side_o  = side_q;

endmodule

`default_nettype wire

// ===== hdl/mi3_div_bank.sv =====
// Divider bank: nine pipelined restoring dividers sharing one divisor.
`default_nettype none

module mi3_div_bank (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  input  mi3_pkg::mi3_front_t                              front_i,
  output logic                                             valid_o,
  output mi3_pkg::mi3_side_t                               side_o,
  output logic [mi3_pkg::MI3_LANES-1:0][mi3_pkg::MI3_QW-1:0] quo_o
);
  import mi3_pkg::*;

  localparam int XW = MI3_RW + MI3_NSTEP;  // widest shifted divisor

  logic [MI3_NSTEP:0]  vld_q;
  mi3_side_t           side_q [0:MI3_NSTEP];
  logic [MI3_RW-1:0]   rem_q  [0:MI3_NSTEP][0:MI3_LANES-1];
  logic [MI3_QW-1:0]   quo_q  [0:MI3_NSTEP][0:MI3_LANES-1];

  // advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[MI3_NSTEP-1:0], valid_i};
    end
  end

  // stage 0: quotient overflow check and scaled dividend
  always_ff @(posedge clk_i) begin
    side_q[0].dmag  <= front_i.dmag;
    side_q[0].dneg  <= front_i.dneg;
    side_q[0].dzero <= front_i.dzero;
    side_q[0].cneg  <= front_i.cneg;
    for (int j = 0; j < MI3_LANES; j++) begin
      // quotient reaches 2^33 when |C| >= 2 * |D|
      side_q[0].ovf[j] <= {33'b0, front_i.cmag[j]} >= {front_i.dmag, 1'b0};
      rem_q[0][j]      <= {front_i.cmag[j], 32'b0};
      quo_q[0][j]      <= '0;
    end
  end

  // stages 1..N: one quotient bit each, most significant first
  for (genvar gs = 1; gs <= MI3_NSTEP; gs++) begin : g_step
    localparam int SH = MI3_NSTEP - gs;

    always_ff @(posedge clk_i) begin
      side_q[gs] <= side_q[gs-1];
    end

    for (genvar gl = 0; gl < MI3_LANES; gl++) begin : g_lane
      logic [XW-1:0] dsh;
      logic          ge;

      assign dsh = {{MI3_NSTEP{1'b0}}, side_q[gs-1].dmag} << SH;
      assign ge  = {{MI3_NSTEP{1'b0}}, rem_q[gs-1][gl]} >= dsh;

      // subtract the shifted divisor where it fits
      always_ff @(posedge clk_i) begin
        rem_q[gs][gl] <= ge ? (rem_q[gs-1][gl] - dsh[MI3_RW-1:0]) : rem_q[gs-1][gl];
        quo_q[gs][gl] <= quo_q[gs-1][gl] | (ge ? (MI3_QW'(1) << SH) : '0);
      end
    end
  end

  assign valid_o = vld_q[MI3_NSTEP];
  assign side_o  = side_q[MI3_NSTEP];

  for (genvar go = 0; go < MI3_LANES; go++) begin : g_out
    assign quo_o[go] = quo_q[MI3_NSTEP][go];
  end

endmodule

`default_nettype wire

// ===== hdl/matrix_inverse_3x3_unit.sv =====
// Top level of the 3x3 matrix inverse: front end, divider bank, clip stage.
//
//  port      dir  word type            handshake
//  matrix_i  in   mi3_pkg::mi3_in_t    start_i high while busy_o low
//  result_o  out  mi3_pkg::mi3_out_t   done_o strobe, one cycle
//
// A word is accepted in every cycle; busy_o stays low.
// Each result passes through seven front stages (products,
// determinant, magnitudes), 34 divider stages (overflow check plus one
// quotient bit per stage for 33 bits) and the clip register.
// Reset clears only the valid bits; words in flight are dropped.
// The receiver takes every result in the cycle it shows, so nothing stalls.
`default_nettype none

module matrix_inverse_3x3_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  mi3_pkg::mi3_in_t    matrix_i,
  output logic                done_o,
  output mi3_pkg::mi3_out_t   result_o
);
  import mi3_pkg::*;

  logic                             fr_valid;
  mi3_front_t                       fr_side;
  logic                             dv_valid;
  mi3_side_t                        dv_side;
  logic [MI3_LANES-1:0][MI3_QW-1:0] dv_quo;

  logic [31:0]          inv_val [MI3_LANES];
  logic [MI3_LANES-1:0] inv_clip;
  logic [63:0]          dq;
  logic                 det_neg;
  logic                 det_clip;
  logic [31:0]          det_val;

  mi3_out_t res_d, res_q;
  logic     done_q;

  assign busy_o = 1'b0;

  mi3_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .matrix_i (matrix_i),
    .valid_o  (fr_valid),
    .side_o   (fr_side)
  );

  mi3_div_bank u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .front_i (fr_side),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quo_o   (dv_quo)
  );

  // clip each quotient to Q16.16 with its sign
  for (genvar gl = 0; gl < MI3_LANES; gl++) begin : g_clip
    logic qneg;
    assign qneg = (dv_side.cneg[gl] ^ dv_side.dneg) &&
                  (dv_side.ovf[gl] || (dv_quo[gl] != '0));
    assign inv_clip[gl] = dv_side.ovf[gl] ||
                          (qneg ? (dv_quo[gl] > 33'h080000000)
                                : (dv_quo[gl] > 33'h07FFFFFFF));
    assign inv_val[gl] = !inv_clip[gl] ? (qneg ? (32'd0 - dv_quo[gl][31:0])
                                               : dv_quo[gl][31:0])
                       : (qneg ? 32'h80000000 : 32'h7FFFFFFF);
  end

  // clip the determinant, Q48.48 down to Q16.16
  assign dq       = dv_side.dmag[95:32];
  assign det_neg  = dv_side.dneg && (dq != '0);
  assign det_clip = det_neg ? (dq > 64'h80000000) : (dq > 64'h7FFFFFFF);
  assign det_val  = !det_clip ? (det_neg ? (32'd0 - dq[31:0]) : dq[31:0])
                  : (det_neg ? 32'h80000000 : 32'h7FFFFFFF);

  // assemble the result word; a zero determinant sets singular and zeroes all other fields
  always_comb begin
    res_d = '0;
    if (dv_side.dzero) begin
      res_d.singular = 1'b1;
    end else begin
      res_d.inv_00    = inv_val[0];
      res_d.inv_01    = inv_val[1];
      res_d.inv_02    = inv_val[2];
      res_d.inv_10    = inv_val[3];
      res_d.inv_11    = inv_val[4];
      res_d.inv_12    = inv_val[5];
      res_d.inv_20    = inv_val[6];
      res_d.inv_21    = inv_val[7];
      res_d.inv_22    = inv_val[8];
      res_d.det_value = det_val;
      res_d.saturated = (|inv_clip) || det_clip;
    end
  end

  // register the strobe and the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== hdl/mi3_checker.sv =====
// Port checker for the 3x3 matrix inverse and its bind.
`default_nettype none

`include "assert_macros.svh"

module mi3_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input mi3_pkg::mi3_out_t result_o
);
  import mi3_pkg::*;

  // the unit never refuses a word
  `MI3_ASSERT_HOLD(a_never_busy, clk_i, rst_ni, !busy_o)

  // every accepted word later yields a strobe on done_o
  `MI3_ASSERT_IMP(a_done_follows, clk_i, rst_ni, start_i && !busy_o, ##MI3_LATENCY done_o)

  // no strobe without a matching accepted word before it
  `MI3_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, done_o, $past(start_i, MI3_LATENCY))

  // a singular result carries zeros and no clip
  `MI3_ASSERT_IMP(a_singular_zero, clk_i, rst_ni, done_o && result_o.singular, (result_o.inv_00 == 0) && (result_o.inv_11 == 0) && (result_o.inv_22 == 0) && (result_o.det_value == 0) && !result_o.saturated)

endmodule

bind matrix_inverse_3x3_unit mi3_checker u_mi3_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire
